@@ hdl/scalar_keyframe_curve_sampler_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keyframe curve sampler
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KEYFRAME_CURVE_SAMPLER_MACROS_SVH
`define SCALAR_KEYFRAME_CURVE_SAMPLER_MACROS_SVH
`ifndef ASSERT_OFF
// check a property outside reset
`define SKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every edge, reset included
`define SKC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKC_ASSERT(lbl, prop, msg)
`define SKC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/skc_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyframe curve sampler package
// Sizes, codes and the key table entry layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package skc_pkg;
  localparam int KEY_DEPTH = 64;
  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = $clog2(KEY_DEPTH);
  localparam int CNT_W     = $clog2(KEY_DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 7;
  localparam int ENTRY_W   = 4 * DATA_W;
  localparam int QCNT_W    = $clog2(FRAC_BITS);
  localparam int T_W       = FRAC_BITS + 1;
  localparam int H_W       = FRAC_BITS + 4;
  localparam int MUL_W     = 40;
  localparam int DIG_W     = 8;
  localparam int MUL_STEPS = MUL_W / DIG_W;
  localparam int MCNT_W    = $clog2(MUL_STEPS);
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = PROD_W + 2;

  localparam logic [H_W-1:0] ONE_H = H_W'(1) << FRAC_BITS;

  localparam logic       FUNC_LOAD   = 1'b0;
  localparam logic       FUNC_SAMPLE = 1'b1;

  localparam logic       REG_KEY_COUNT   = 1'b0;
  localparam logic       REG_INTERP_MODE = 1'b1;

  localparam logic [1:0] MODE_STEP    = 2'd0;
  localparam logic [1:0] MODE_LINEAR  = 2'd1;
  localparam logic [1:0] MODE_HERMITE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] out_slope;
    logic [DATA_W-1:0] in_slope;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] ktime;
  } key_entry_t;
endpackage

@@ hdl/skc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module skc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/skc_mul.sv @@
// ----------------------------------------------------------------------------
// Sequential signed multiplier
// Multiplies two signed words one 8-bit digit of the second per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module skc_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [skc_pkg::MUL_W-1:0]  a,
  input  logic signed [skc_pkg::MUL_W-1:0]  b,
  output logic                              done,
  output logic signed [skc_pkg::PROD_W-1:0] p
);
  import skc_pkg::*;

  logic                     busy;
  logic [MCNT_W-1:0]        cnt;
  logic signed [PROD_W-1:0] a_sh;
  logic signed [PROD_W-1:0] acc;
  logic [MUL_W-1:0]         b_sh;
  logic                     last;
  logic signed [DIG_W:0]    dig;
  logic signed [PROD_W-1:0] pp;

  // lower digits are unsigned, the top digit carries the sign
  assign last = (cnt == MCNT_W'(MUL_STEPS - 1));
  assign dig  = last ? $signed({b_sh[DIG_W-1], b_sh[DIG_W-1:0]})
                     : $signed({1'b0, b_sh[DIG_W-1:0]});
  assign pp   = a_sh * dig;
  assign p    = acc;

  // accumulate one partial product a cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      a_sh <= PROD_W'(a);
      b_sh <= b;
      acc  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      acc  <= acc + pp;
      a_sh <= a_sh <<< DIG_W;
      b_sh <= b_sh >> DIG_W;
      cnt  <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end
endmodule

@@ hdl/scalar_keyframe_curve_sampler.sv @@
// ----------------------------------------------------------------------------
// Scalar keyframe curve sampler
// Keyframe table with step, linear and cubic Hermite sampling in Q16.16.
// ----------------------------------------------------------------------------
// One request is taken at a time. A load writes one key into the table RAM
// and then answers. A sample scans the first key_count keys, at most 64,
// through the single RAM read port (one key a cycle, which also finds the
// enclosing pair), then runs a restoring divide for the 16-bit fraction and
// the shared digit-serial multiplier: once for linear, eight times for
// Hermite. Empty-table, clamped and step results skip the divide and the
// multiplier.
`timescale 1ns / 1ps
module scalar_keyframe_curve_sampler (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [skc_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // key_slot[5:0], key_time, key_value, key_in_slope, key_out_slope,
  // sample_time, prior_value, two zero pad bits
  input  logic [199:0]                 s_tdata,
  // func
  input  logic [0:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // value
  output logic [31:0]                  m_tdata,
  // status
  output logic [1:0]                   m_tuser
);
  import skc_pkg::*;
  `include "scalar_keyframe_curve_sampler_macros.svh"

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PRIME  = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_EVAL   = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_MSTART = 4'd5;
  localparam logic [3:0] S_MWAIT  = 4'd6;
  localparam logic [3:0] S_SAT    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0]         state;
  logic [CFG_W-1:0]   key_count;
  logic [1:0]         interp_mode;
  logic [CNT_W-1:0]   n;

  logic               func;
  logic [5:0]         key_slot;
  key_entry_t         key_in;
  logic [31:0]        sample_time;
  logic [31:0]        prior_value;
  logic               accept;

  logic               ram_we;
  logic [ADDR_W-1:0]  ra;
  logic [ENTRY_W-1:0] rdata;
  key_entry_t         cur;

  logic [ADDR_W-1:0]  ridx;
  logic [CNT_W-1:0]   ridx_x;
  key_entry_t         prev_e;
  key_entry_t         left_e;
  key_entry_t         right_e;
  logic [31:0]        samp_t;
  logic [31:0]        first_time;
  logic [31:0]        first_val;
  logic [31:0]        last_time;
  logic [31:0]        last_val;
  logic               order_err;
  logic               found;

  logic [32:0]        dur;
  logic [32:0]        rem;
  logic [33:0]        rem2;
  logic [33:0]        dur_x;
  logic               ge;
  logic [FRAC_BITS-1:0] alpha;
  logic [QCNT_W-1:0]  qcnt;
  logic signed [32:0] lt_x;
  logic signed [32:0] rt_x;
  logic signed [32:0] t_x;
  logic signed [32:0] lv_x;
  logic signed [32:0] rv_x;
  logic signed [32:0] dv;

  logic [2:0]               mstep;
  logic                     mul_start;
  logic                     mul_done;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] psh;
  logic signed [ACC_W-1:0]  p_ext;
  logic signed [T_W-1:0]    t2;
  logic signed [T_W-1:0]    t3;
  logic signed [H_W-1:0]    t2x;
  logic signed [H_W-1:0]    t3x;
  logic signed [H_W-1:0]    h00;
  logic signed [H_W-1:0]    h10;
  logic signed [H_W-1:0]    h01;
  logic signed [H_W-1:0]    h11;
  logic signed [H_W-1:0]    ax;
  logic signed [MUL_W-1:0]  hd10;
  logic signed [MUL_W-1:0]  hd11;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  res;
  logic [ACC_W-32:0]        res_hi;

  logic [1:0]         fin_status;
  logic [31:0]        fin_value;
  logic               out_free;

  // unpack the request
  assign func        = s_tuser[0];
  assign key_slot    = s_tdata[5:0];
  assign key_in      = '{out_slope: s_tdata[133:102], in_slope: s_tdata[101:70],
                         value: s_tdata[69:38], ktime: s_tdata[37:6]};
  assign sample_time = s_tdata[165:134];
  assign prior_value = s_tdata[197:166];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign n = (32'(key_count) > KEY_DEPTH) ? CNT_W'(KEY_DEPTH) : CNT_W'(key_count);

  // key table: written by loads, scanned by samples
  assign ram_we = accept && (func == FUNC_LOAD) && (32'(key_slot) < KEY_DEPTH);

  skc_ram #(.WIDTH(ENTRY_W), .DEPTH(KEY_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(key_slot)),
    .wdata (key_in),
    .raddr (ra),
    .rdata (rdata)
  );

  assign cur    = key_entry_t'(rdata);
  assign ridx_x = CNT_W'(ridx);

  // differences for the fraction
  assign lt_x = {left_e.ktime[31], left_e.ktime};
  assign rt_x = {right_e.ktime[31], right_e.ktime};
  assign t_x  = {samp_t[31], samp_t};
  assign lv_x = {left_e.value[31], left_e.value};
  assign rv_x = {right_e.value[31], right_e.value};
  assign dv   = rv_x - lv_x;

  // one restoring divide step
  assign rem2  = {rem, 1'b0};
  assign dur_x = {1'b0, dur};
  assign ge    = (rem2 >= dur_x);

  // Hermite basis weights
  assign t2x = H_W'(t2);
  assign t3x = H_W'(t3);
  assign ax  = H_W'({1'b0, alpha});
  assign h00 = (t3x <<< 1) - (t2x + (t2x <<< 1)) + $signed(ONE_H);
  assign h10 = t3x - (t2x <<< 1) + ax;
  assign h01 = (t2x + (t2x <<< 1)) - (t3x <<< 1);
  assign h11 = t3x - t2x;

  // select multiplier operands for the current step
  always_comb begin
    mul_a = MUL_W'(dv);
    mul_b = MUL_W'({1'b0, alpha});
    if (interp_mode == MODE_HERMITE) begin
      case (mstep)
        3'd0: begin
          mul_a = MUL_W'({1'b0, alpha});
          mul_b = MUL_W'({1'b0, alpha});
        end
        3'd1: begin
          mul_a = MUL_W'(t2);
          mul_b = MUL_W'({1'b0, alpha});
        end
        3'd2: begin
          mul_a = MUL_W'(h10);
          mul_b = MUL_W'(dur);
        end
        3'd3: begin
          mul_a = MUL_W'(h11);
          mul_b = MUL_W'(dur);
        end
        3'd4: begin
          mul_a = MUL_W'($signed(left_e.value));
          mul_b = MUL_W'(h00);
        end
        3'd5: begin
          mul_a = MUL_W'($signed(left_e.out_slope));
          mul_b = hd10;
        end
        3'd6: begin
          mul_a = MUL_W'($signed(right_e.value));
          mul_b = MUL_W'(h01);
        end
        default: begin
          mul_a = MUL_W'($signed(right_e.in_slope));
          mul_b = hd11;
        end
      endcase
    end
  end

  assign mul_start = (state == S_MSTART);

  skc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign psh    = mul_p >>> FRAC_BITS;
  assign p_ext  = ACC_W'(mul_p);
  assign res_hi = res[ACC_W-1:31];

  // configuration registers
  always_ff @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_index)
        REG_KEY_COUNT:   key_count   <= cfg_data;
        REG_INTERP_MODE: interp_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
    if (rst) begin
      key_count   <= '0;
      interp_mode <= MODE_LINEAR;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      m_tvalid <= 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          samp_t    <= sample_time;
          order_err <= 1'b0;
          found     <= 1'b0;
          ra        <= '0;
          if (func == FUNC_LOAD) begin
            fin_status <= ST_OK;
            fin_value  <= '0;
            state      <= S_FIN;
          end else if (n == '0) begin
            fin_status <= ST_OK;
            fin_value  <= prior_value;
            state      <= S_FIN;
          end else begin
            state <= S_PRIME;
          end
        end
      end
      S_PRIME: begin
        ra    <= ra + 1'b1;
        ridx  <= '0;
        state <= S_SCAN;
      end
      S_SCAN: begin
        // check order and find the first key later than the sample time
        if (ridx != '0 && $signed(cur.ktime) < $signed(prev_e.ktime)) begin
          order_err <= 1'b1;
        end
        if (ridx == '0) begin
          first_time <= cur.ktime;
          first_val  <= cur.value;
        end
        if (!found && ridx != '0 && ridx_x < n - 1'b1 &&
            $signed(cur.ktime) > $signed(samp_t)) begin
          found   <= 1'b1;
          left_e  <= prev_e;
          right_e <= cur;
        end
        prev_e <= cur;
        if (ridx_x == n - 1'b1) begin
          last_time <= cur.ktime;
          last_val  <= cur.value;
          if (!found) begin
            left_e  <= prev_e;
            right_e <= cur;
          end
          state <= S_EVAL;
        end else begin
          ridx <= ridx + 1'b1;
          ra   <= ra + 1'b1;
        end
      end
      S_EVAL: begin
        fin_status <= ST_OK;
        if (order_err) begin
          fin_status <= ST_ORDER;
          fin_value  <= '0;
          state      <= S_FIN;
        end else if (n == CNT_W'(1) || $signed(samp_t) <= $signed(first_time)) begin
          fin_value <= first_val;
          state     <= S_FIN;
        end else if ($signed(samp_t) >= $signed(last_time)) begin
          fin_value <= last_val;
          state     <= S_FIN;
        end else if (interp_mode == MODE_STEP) begin
          fin_value <= left_e.value;
          state     <= S_FIN;
        end else begin
          dur   <= 33'(rt_x - lt_x);
          rem   <= 33'(t_x - lt_x);
          qcnt  <= '0;
          state <= S_DIV;
        end
      end
      S_DIV: begin
        rem   <= ge ? 33'(rem2 - dur_x) : rem2[32:0];
        alpha <= {alpha[FRAC_BITS-2:0], ge};
        qcnt  <= qcnt + 1'b1;
        if (qcnt == QCNT_W'(FRAC_BITS - 1)) begin
          mstep <= '0;
          state <= S_MSTART;
        end
      end
      S_MSTART: begin
        state <= S_MWAIT;
      end
      S_MWAIT: begin
        if (mul_done) begin
          state <= S_MSTART;
          mstep <= mstep + 1'b1;
          if (interp_mode != MODE_HERMITE) begin
            res   <= ACC_W'($signed(left_e.value)) + ACC_W'(psh);
            state <= S_SAT;
          end else begin
            case (mstep)
              3'd0: t2   <= psh[T_W-1:0];
              3'd1: t3   <= psh[T_W-1:0];
              3'd2: hd10 <= psh[MUL_W-1:0];
              3'd3: hd11 <= psh[MUL_W-1:0];
              3'd4: acc  <= p_ext;
              3'd5: acc  <= acc + p_ext;
              3'd6: acc  <= acc + p_ext;
              default: begin
                res   <= (acc + p_ext) >>> FRAC_BITS;
                state <= S_SAT;
              end
            endcase
          end
        end
      end
      S_SAT: begin
        // clamp to the signed 32-bit range
        if (res_hi == '0 || res_hi == '1) begin
          fin_status <= ST_OK;
          fin_value  <= res[31:0];
        end else begin
          fin_status <= ST_SAT;
          fin_value  <= res[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        state <= S_FIN;
      end
      S_FIN: begin
        // hand the result to the output register once it is free
        if (out_free) begin
          m_tvalid <= 1'b1;
          m_tdata  <= fin_value;
          m_tuser  <= fin_status;
          state    <= S_IDLE;
        end
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end
  end

  `SKC_ASSERT(a_fin_holds, (state == S_FIN && m_tvalid && !m_tready) |=> (state == S_FIN), "result left before the output register freed")
  `SKC_ASSERT(a_load_answers, (accept && func == FUNC_LOAD) |=> (state == S_FIN), "load did not go straight to its answer")
  `SKC_ASSERT(a_mul_done_wait, mul_done |-> (state == S_MWAIT), "multiplier finished outside its wait state")
  `SKC_ASSERT(a_scan_bound, (state == S_SCAN) |-> (ridx_x < n), "scan ran past the key count")
  `SKC_ASSERT_ALWAYS(a_ready_rst, rst |=> (state == S_IDLE), "sequencer not idle after reset")
endmodule
